/* design/rid_pkg.sv */
`default_nettype none

package rid_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_IMAGE_WIDTH      = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT     = 3'd1;
    localparam logic [2:0] REG_ORIGIN_X         = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Y         = 3'd3;
    localparam logic [2:0] REG_TRANSPARENT_MODE = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int RUN_W       = 8;
    localparam int COLOR_W     = 8;
    localparam int COORD_W     = 12;

    // Lower limits of the image sides
    localparam int MIN_WIDTH  = 8;
    localparam int MIN_HEIGHT = 1;

    // Palette index that transparent mode leaves undrawn
    localparam logic [COLOR_W-1:0] TRANSPARENT_INDEX = '0;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } rid_state_t;

    typedef struct packed
    {
        logic load_item;
        logic emit_span;
    } rid_cmd_t;

    typedef struct packed
    {
        logic out_free;
        logic step_last;
    } rid_status_t;

endpackage

`default_nettype wire

/* design/rid_ctrl.sv */
`default_nettype none

module rid_ctrl
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  rid_pkg::rid_status_t status,
    output rid_pkg::rid_cmd_t    cmd
);

    rid_pkg::rid_state_t state_reg;
    rid_pkg::rid_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rid_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rid_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rid_pkg::ST_RUN;
                end
            end
            rid_pkg::ST_RUN:
            begin
                if (status.out_free && status.step_last)
                begin
                    state_next = rid_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rid_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        cmd.load_item = 1'b0;
        cmd.emit_span = 1'b0;
        unique case (state_reg)
            rid_pkg::ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_item = in_valid;
            end
            rid_pkg::ST_RUN:
            begin
                cmd.emit_span = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/rid_datapath.sv */
`default_nettype none

module rid_datapath
#(
    parameter int MAX_IMAGE_SIDE = 1024
)
(
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  rid_pkg::rid_cmd_t                      cmd,
    output rid_pkg::rid_status_t                   status,
    input  wire        [rid_pkg::RUN_W-1:0]        run_length,
    input  wire        [rid_pkg::COLOR_W-1:0]      color_index,
    input  wire                                    cfg_valid,
    input  wire        [rid_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire        [rid_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                   out_valid,
    input  wire                                    out_stall,
    output logic signed [rid_pkg::COORD_W-1:0]     span_x,
    output logic signed [rid_pkg::COORD_W-1:0]     span_y,
    output logic       [rid_pkg::RUN_W-1:0]        span_length,
    output logic       [rid_pkg::COLOR_W-1:0]      span_color,
    output logic                                   draw_enable,
    output logic                                   image_done,
    output logic                                   last_span
);

    localparam int CW = $clog2(MAX_IMAGE_SIDE);
    localparam int SW = CW + 1;
    localparam int RW = CW + 1;
    localparam int AW = 16;

    localparam int CDW = rid_pkg::CFG_DATA_W;
    localparam int XW  = rid_pkg::COORD_W;

    // configuration, sides held already clamped
    logic [SW-1:0]  width_reg;
    logic [SW-1:0]  height_reg;
    logic [CDW-1:0] ox_reg;
    logic [CDW-1:0] oy_reg;
    logic           transp_reg;

    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;

    logic [rid_pkg::RUN_W-1:0]   rem_reg;
    logic [rid_pkg::COLOR_W-1:0] color_reg;
    logic                        draw_reg;

    logic                        out_valid_reg;
    logic [XW-1:0]               span_x_reg;
    logic [XW-1:0]               span_y_reg;
    logic [rid_pkg::RUN_W-1:0]   span_length_reg;
    logic [rid_pkg::COLOR_W-1:0] span_color_reg;
    logic                        draw_enable_reg;
    logic                        image_done_reg;
    logic                        last_span_reg;

    logic [AW-1:0] cfg_wide;
    logic [AW-1:0] max_wide;
    logic [SW-1:0] width_clamped;
    logic [SW-1:0] height_clamped;
    logic          cfg_hit;

    logic [AW-1:0] col_wide;
    logic [AW-1:0] row_wide;
    logic [AW-1:0] width_wide;
    logic [AW-1:0] height_wide;
    logic [AW-1:0] rem_wide;
    logic [AW-1:0] room;
    logic          wrap;
    logic [rid_pkg::RUN_W-1:0] n;
    logic [rid_pkg::RUN_W-1:0] rem_next;
    logic [AW-1:0] col_sum;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic [AW-1:0] row_next_wide;
    logic          empty_item;
    logic          done_after;
    logic          stop;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] pos_y;

    assign cfg_wide = AW'(cfg_data);
    assign max_wide = AW'(MAX_IMAGE_SIDE);

    always_comb
    begin
        priority if (cfg_wide < AW'(rid_pkg::MIN_WIDTH))
        begin
            width_clamped = SW'(rid_pkg::MIN_WIDTH);
        end
        else if (cfg_wide > max_wide)
        begin
            width_clamped = max_wide[SW-1:0];
        end
        else
        begin
            width_clamped = cfg_wide[SW-1:0];
        end

        priority if (cfg_wide < AW'(rid_pkg::MIN_HEIGHT))
        begin
            height_clamped = SW'(rid_pkg::MIN_HEIGHT);
        end
        else if (cfg_wide > max_wide)
        begin
            height_clamped = max_wide[SW-1:0];
        end
        else
        begin
            height_clamped = cfg_wide[SW-1:0];
        end
    end

    assign cfg_hit = cfg_valid && (cfg_index == rid_pkg::REG_IMAGE_WIDTH
                                || cfg_index == rid_pkg::REG_IMAGE_HEIGHT
                                || cfg_index == rid_pkg::REG_ORIGIN_X
                                || cfg_index == rid_pkg::REG_ORIGIN_Y
                                || cfg_index == rid_pkg::REG_TRANSPARENT_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SW'(16);
            height_reg <= SW'(16);
            ox_reg     <= '0;
            oy_reg     <= '0;
            transp_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rid_pkg::REG_IMAGE_WIDTH:      width_reg  <= width_clamped;
                rid_pkg::REG_IMAGE_HEIGHT:     height_reg <= height_clamped;
                rid_pkg::REG_ORIGIN_X:         ox_reg     <= cfg_data;
                rid_pkg::REG_ORIGIN_Y:         oy_reg     <= cfg_data;
                rid_pkg::REG_TRANSPARENT_MODE: transp_reg <= cfg_data[0];
                default:                       transp_reg <= transp_reg;
            endcase
        end
    end

    // one span step
    assign col_wide    = AW'(col_reg);
    assign row_wide    = AW'(row_reg);
    assign width_wide  = AW'(width_reg);
    assign height_wide = AW'(height_reg);
    assign rem_wide    = AW'(rem_reg);
    assign room        = width_wide - col_wide;
    assign wrap        = rem_wide >= room;
    assign n           = wrap ? room[rid_pkg::RUN_W-1:0] : rem_reg;
    assign rem_next    = rem_reg - n;
    assign col_sum     = col_wide + AW'(n);
    assign col_next    = wrap ? '0 : col_sum[CW-1:0];
    assign row_next    = wrap ? row_reg + RW'(1) : row_reg;
    assign row_next_wide = AW'(row_next);
    assign empty_item  = (rem_reg == '0) || (row_wide >= height_wide);
    assign done_after  = row_next_wide >= height_wide;
    assign stop        = (rem_next == '0) || done_after;

    assign pos_x = {ox_reg[CDW-1], ox_reg} + col_wide[XW-1:0];
    assign pos_y = {oy_reg[CDW-1], oy_reg} + row_wide[XW-1:0];

    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.step_last = empty_item || stop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.emit_span && !empty_item)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            rem_reg   <= run_length;
            color_reg <= color_index;
            draw_reg  <= !(transp_reg && color_index == rid_pkg::TRANSPARENT_INDEX);
        end
        else if (cmd.emit_span && !empty_item)
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_span)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_span)
        begin
            span_x_reg <= pos_x;
            span_y_reg <= pos_y;
            if (empty_item)
            begin
                span_length_reg <= '0;
                span_color_reg  <= '0;
                draw_enable_reg <= 1'b0;
                image_done_reg  <= row_wide >= height_wide;
                last_span_reg   <= 1'b1;
            end
            else
            begin
                span_length_reg <= n;
                span_color_reg  <= color_reg;
                draw_enable_reg <= draw_reg;
                image_done_reg  <= done_after;
                last_span_reg   <= stop;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign span_x      = span_x_reg;
    assign span_y      = span_y_reg;
    assign span_length = span_length_reg;
    assign span_color  = span_color_reg;
    assign draw_enable = draw_enable_reg;
    assign image_done  = image_done_reg;
    assign last_span   = last_span_reg;

endmodule

`default_nettype wire

/* design/run_index_pixel_decoder_core.sv */
// An item is taken in the idle state; in the run state its spans are then registered at
// the output, one span per cycle while the output is free. No new item is taken until
// the last span of the item has been registered: an item gives S spans (1 .. 33), one per image
// row the run touches, or one for a zero run or a finished image.
// Reset: asynchronous, active low; registers return to 16 x 16 at origin 0, opaque,
// position at the top left, no span pending.
`default_nettype none

module run_index_pixel_decoder_core
#(
    parameter int MAX_IMAGE_SIDE = 1024
)
(
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    output logic                                   in_stall,
    input  wire        [rid_pkg::RUN_W-1:0]        run_length,
    input  wire        [rid_pkg::COLOR_W-1:0]      color_index,
    output logic                                   out_valid,
    input  wire                                    out_stall,
    output logic signed [rid_pkg::COORD_W-1:0]     span_x,
    output logic signed [rid_pkg::COORD_W-1:0]     span_y,
    output logic       [rid_pkg::RUN_W-1:0]        span_length,
    output logic       [rid_pkg::COLOR_W-1:0]      span_color,
    output logic                                   draw_enable,
    output logic                                   image_done,
    output logic                                   last_span,
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire        [rid_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire        [rid_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rid_pkg::rid_cmd_t    cmd;
    rid_pkg::rid_status_t status;

    assign cfg_ready = 1'b1;

    rid_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rid_datapath
    #(
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .run_length  (run_length),
        .color_index (color_index),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .span_x      (span_x),
        .span_y      (span_y),
        .span_length (span_length),
        .span_color  (span_color),
        .draw_enable (draw_enable),
        .image_done  (image_done),
        .last_span   (last_span)
    );

    // no second item while the first is still producing spans
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item taken while previous item still busy");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && span_length == '0 |-> last_span && !draw_enable)
        else $error("empty span not marked last or drawn");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_done |-> last_span)
        else $error("image finished but span not last");

endmodule

`default_nettype wire

/* test/span_stream_checker.sv */
`default_nettype none

module span_stream_checker
#(
    parameter int MAX_SIDE = 1024
)
(
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    in_valid,
    input  wire                                    in_stall,
    input  wire        [rid_pkg::RUN_W-1:0]        run_length,
    input  wire        [rid_pkg::COLOR_W-1:0]      color_index,
    input  wire                                    out_valid,
    input  wire                                    out_stall,
    input  wire signed [rid_pkg::COORD_W-1:0]      span_x,
    input  wire signed [rid_pkg::COORD_W-1:0]      span_y,
    input  wire        [rid_pkg::RUN_W-1:0]        span_length,
    input  wire        [rid_pkg::COLOR_W-1:0]      span_color,
    input  wire                                    draw_enable,
    input  wire                                    image_done,
    input  wire                                    last_span,
    input  wire                                    cfg_valid,
    input  wire                                    cfg_ready,
    input  wire        [rid_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire        [rid_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                     fail_count,
    output int                                     pending
);

    localparam int MAX_SPANS = 33;
    localparam int XW        = rid_pkg::COORD_W;
    localparam int LW        = rid_pkg::RUN_W;

    typedef struct
    {
        logic signed [rid_pkg::COORD_W-1:0] x;
        logic signed [rid_pkg::COORD_W-1:0] y;
        logic [rid_pkg::RUN_W-1:0]          len;
        logic [rid_pkg::COLOR_W-1:0]        color;
        logic                               draw;
        logic                               done;
        logic                               last;
    } span_rec_t;

    span_rec_t spans_due[$];
    span_rec_t oldest;

    logic        [rid_pkg::CFG_DATA_W-1:0] width_reg;
    logic        [rid_pkg::CFG_DATA_W-1:0] height_reg;
    logic signed [rid_pkg::CFG_DATA_W-1:0] origin_x_reg;
    logic signed [rid_pkg::CFG_DATA_W-1:0] origin_y_reg;
    logic                                  transparent_reg;
    int                                    column;
    int                                    row;

    task automatic apply_setting(input logic [rid_pkg::CFG_INDEX_W-1:0] idx,
                                 input logic [rid_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            rid_pkg::REG_IMAGE_WIDTH:      width_reg = data;
            rid_pkg::REG_IMAGE_HEIGHT:     height_reg = data;
            rid_pkg::REG_ORIGIN_X:         origin_x_reg = data;
            rid_pkg::REG_ORIGIN_Y:         origin_y_reg = data;
            rid_pkg::REG_TRANSPARENT_MODE: transparent_reg = data[0];
            default: ;
        endcase
        // indexes past the list leave the position alone
        if (idx <= rid_pkg::REG_TRANSPARENT_MODE)
        begin
            column = 0;
            row = 0;
        end
    endtask

    task automatic decode_run(input logic [rid_pkg::RUN_W-1:0] rl,
                              input logic [rid_pkg::COLOR_W-1:0] ci);
        int        remaining;
        int        wd;
        int        ht;
        int        ox;
        int        oy;
        int        room;
        int        n;
        int        count;
        logic      drw;
        span_rec_t s;
        remaining = int'(rl);
        wd = (int'(width_reg) < rid_pkg::MIN_WIDTH) ? rid_pkg::MIN_WIDTH
           : ((int'(width_reg) > MAX_SIDE) ? MAX_SIDE : int'(width_reg));
        ht = (int'(height_reg) < rid_pkg::MIN_HEIGHT) ? rid_pkg::MIN_HEIGHT
           : ((int'(height_reg) > MAX_SIDE) ? MAX_SIDE : int'(height_reg));
        ox = int'(origin_x_reg);
        oy = int'(origin_y_reg);
        drw = !(transparent_reg && ci == rid_pkg::TRANSPARENT_INDEX);
        count = 0;
        if (column >= wd)
            column = 0;
        if (remaining == 0 || row >= ht)
        begin
            // empty span at the current position
            s.x = XW'(ox + column);
            s.y = XW'(oy + row);
            s.len = '0;
            s.color = '0;
            s.draw = 1'b0;
            s.done = (row >= ht);
            s.last = 1'b1;
            spans_due.push_back(s);
        end
        else
        begin
            while (remaining != 0 && row < ht && count < MAX_SPANS)
            begin
                room = wd - column;
                n = (remaining < room) ? remaining : room;
                s.x = XW'(ox + column);
                s.y = XW'(oy + row);
                column += n;
                if (column >= wd)
                begin
                    column = 0;
                    row++;
                end
                remaining -= n;
                s.len = LW'(n);
                s.color = ci;
                s.draw = drw;
                s.done = (row >= ht);
                s.last = (remaining == 0) || (row >= ht);
                spans_due.push_back(s);
                count++;
            end
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = 11'd16;
            height_reg = 11'd16;
            origin_x_reg = '0;
            origin_y_reg = '0;
            transparent_reg = 1'b0;
            column = 0;
            row = 0;
            spans_due.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_setting(cfg_index, cfg_data);
            if (out_valid && !out_stall)
            begin
                if (spans_due.size() == 0)
                begin
                    $display("%0t unexpected span: expected none, got x=%0d y=%0d len=%0d",
                             $time, span_x, span_y, span_length);
                    fail_count++;
                end
                else
                begin
                    oldest = spans_due.pop_front();
                    check_field("span_x", int'(span_x), int'(oldest.x));
                    check_field("span_y", int'(span_y), int'(oldest.y));
                    check_field("span_length", int'(span_length), int'(oldest.len));
                    check_field("span_color", int'(span_color), int'(oldest.color));
                    check_field("draw_enable", int'(draw_enable), int'(oldest.draw));
                    check_field("image_done", int'(image_done), int'(oldest.done));
                    check_field("last_span", int'(last_span), int'(oldest.last));
                end
            end
            if (in_valid && !in_stall)
                decode_run(run_length, color_index);
            pending = spans_due.size();
        end
    end

endmodule

`default_nettype wire

/* test/tb_run_index_pixel_decoder_core.sv */
`default_nettype none

module tb_run_index_pixel_decoder_core;

    localparam int MAX_SIDE     = 1024;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 105;

    localparam int CIW = rid_pkg::CFG_INDEX_W;
    localparam int CDW = rid_pkg::CFG_DATA_W;
    localparam int RLW = rid_pkg::RUN_W;
    localparam int CLW = rid_pkg::COLOR_W;

    localparam logic [CIW-1:0] REG_UNUSED_LO = rid_pkg::REG_TRANSPARENT_MODE + 1'b1;
    localparam logic [CIW-1:0] REG_UNUSED_HI = '1;

    localparam logic [CDW-1:0] ORIGIN_MIN = 11'h400;
    localparam logic [CDW-1:0] ORIGIN_MAX = 11'h3FF;

    typedef enum logic [1:0]
    {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_mode_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic        [RLW-1:0]               run_length;
    logic        [CLW-1:0]               color_index;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [rid_pkg::COORD_W-1:0]  span_x;
    logic signed [rid_pkg::COORD_W-1:0]  span_y;
    logic        [RLW-1:0]               span_length;
    logic        [CLW-1:0]               span_color;
    logic                                draw_enable;
    logic                                image_done;
    logic                                last_span;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic        [CIW-1:0]               cfg_index;
    logic        [CDW-1:0]               cfg_data;

    int          fail_count;
    int          pending;
    int          burst_left = 0;
    int          stim_width = 16;
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          stall_period = 4;
    int          stall_duty = 1;
    int          stall_phase = 0;

    always #1 clk = ~clk;

    run_index_pixel_decoder_core #(.MAX_IMAGE_SIDE(MAX_SIDE)) DUT
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .run_length(run_length), .color_index(color_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .span_x(span_x), .span_y(span_y), .span_length(span_length),
        .span_color(span_color), .draw_enable(draw_enable),
        .image_done(image_done), .last_span(last_span),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    span_stream_checker #(.MAX_SIDE(MAX_SIDE)) u_checker
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .run_length(run_length), .color_index(color_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .span_x(span_x), .span_y(span_y), .span_length(span_length),
        .span_color(span_color), .draw_enable(draw_enable),
        .image_done(image_done), .last_span(last_span),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver back-pressure: free, random or periodic, with the mode and its period picked anew at random
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(16, 96);
            stall_period = $urandom_range(2, 9);
            stall_duty = $urandom_range(1, stall_period - 1);
        end
        mode_left--;
        stall_phase = (stall_phase + 1) % stall_period;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 40);
            default:      out_stall <= (stall_phase < stall_duty);
        endcase
    end

    task automatic write_setting(input logic [CIW-1:0] idx,
                                 input logic [CDW-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic [RLW-1:0] rl, input logic [CLW-1:0] ci);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        run_length <= rl;
        color_index <= ci;
        do @(posedge clk); while (in_stall);
    endtask

    // block is idle once every span is out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int                    random_items;
        int                    phase_items;
        int                    unused_at;
        int                    run_cap;
        int                    height_pick;
        bit                    wrote;
        logic [RLW-1:0]        rl;
        logic [CLW-1:0]        ci;
        rst_n = 1'b0;
        in_valid = 1'b0;
        run_length = '0;
        color_index = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset setting: zero run, opaque index 0, a run that exactly fills the image,
        // then inputs after the last row
        send_item(8'd0, 8'h00);
        send_item(8'd1, 8'h00);
        send_item(8'd255, 8'hFF);
        send_item(8'd5, 8'h3C);
        send_item(8'd0, 8'hAA);
        settle();

        // width below the minimum, two rows, corner origin, transparent
        write_setting(rid_pkg::REG_IMAGE_WIDTH, 11'd7);
        write_setting(rid_pkg::REG_IMAGE_HEIGHT, 11'd2);
        write_setting(rid_pkg::REG_ORIGIN_X, ORIGIN_MIN);
        write_setting(rid_pkg::REG_ORIGIN_Y, ORIGIN_MAX);
        write_setting(rid_pkg::REG_TRANSPARENT_MODE, 11'd1);
        stim_width = 8;
        send_item(8'd3, 8'h00);
        send_item(8'd4, 8'h80);
        send_item(8'd20, 8'h00);
        send_item(8'd0, 8'h00);
        send_item(8'd7, 8'h01);
        settle();

        // oversized width and zero height saturate; overrun of the only row
        write_setting(rid_pkg::REG_IMAGE_WIDTH, 11'h7FF);
        write_setting(rid_pkg::REG_IMAGE_HEIGHT, 11'd0);
        write_setting(rid_pkg::REG_ORIGIN_X, ORIGIN_MAX);
        write_setting(rid_pkg::REG_ORIGIN_Y, ORIGIN_MIN);
        write_setting(rid_pkg::REG_TRANSPARENT_MODE, 11'd0);
        stim_width = MAX_SIDE;
        send_item(8'd255, 8'h80);
        send_item(8'd255, 8'h7F);
        settle();
        write_setting(REG_UNUSED_LO, 11'h555);
        send_item(8'd255, 8'h00);
        settle();
        write_setting(REG_UNUSED_HI, 11'h2AA);
        send_item(8'd255, 8'h55);
        send_item(8'd10, 8'hC3);
        send_item(8'd1, 8'h01);
        settle();

        // narrowest rows, tallest image: long runs give the most spans per item
        write_setting(rid_pkg::REG_IMAGE_WIDTH, 11'd8);
        write_setting(rid_pkg::REG_IMAGE_HEIGHT, 11'd1024);
        write_setting(rid_pkg::REG_ORIGIN_X, 11'd0);
        write_setting(rid_pkg::REG_ORIGIN_Y, 11'd0);
        write_setting(rid_pkg::REG_TRANSPARENT_MODE, 11'd1);
        stim_width = 8;
        send_item(8'd255, 8'h00);
        send_item(8'd255, 8'h11);
        send_item(8'd0, 8'h00);
        send_item(8'd128, 8'h40);
        settle();

        write_setting(rid_pkg::REG_IMAGE_WIDTH, 11'd1024);
        write_setting(rid_pkg::REG_IMAGE_HEIGHT, 11'd1);
        stim_width = MAX_SIDE;
        send_item(8'd255, 8'hFE);
        send_item(8'd1, 8'h00);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            wrote = 1'b0;
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 9))
                    0:       stim_width = $urandom_range(0, 2047);
                    1:       stim_width = ($urandom_range(0, 1)) ? $urandom_range(0, 8)
                                                                 : $urandom_range(1020, 1030);
                    default: stim_width = $urandom_range(8, 40);
                endcase
                write_setting(rid_pkg::REG_IMAGE_WIDTH, CDW'(stim_width));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 9))
                    0:       height_pick = $urandom_range(0, 2047);
                    1:       height_pick = ($urandom_range(0, 1)) ? 0 : 2047;
                    default: height_pick = $urandom_range(1, 6);
                endcase
                write_setting(rid_pkg::REG_IMAGE_HEIGHT, CDW'(height_pick));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1))
            begin
                write_setting(rid_pkg::REG_ORIGIN_X, CDW'($urandom_range(0, 2047)));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1))
            begin
                write_setting(rid_pkg::REG_ORIGIN_Y, CDW'($urandom_range(0, 2047)));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1) || !wrote)
                write_setting(rid_pkg::REG_TRANSPARENT_MODE, CDW'($urandom_range(0, 2047)));

            if (stim_width < rid_pkg::MIN_WIDTH)
                run_cap = 2 * rid_pkg::MIN_WIDTH;
            else if (stim_width > 127)
                run_cap = 255;
            else
                run_cap = 2 * stim_width;

            phase_items = $urandom_range(3, 12);
            unused_at = $urandom_range(0, 3 * phase_items);
            for (int k = 0; k < phase_items; k++)
            begin
                if (k == unused_at && k != 0)
                begin
                    settle();
                    write_setting(CIW'(REG_UNUSED_LO + $urandom_range(0, 2)),
                                  CDW'($urandom_range(0, 2047)));
                end
                case ($urandom_range(0, 9))
                    0:       rl = 8'd0;
                    1:       rl = 8'd255;
                    2:       rl = RLW'($urandom_range(0, 255));
                    default: rl = RLW'($urandom_range(1, run_cap));
                endcase
                ci = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
                send_item(rl, ci);
                random_items++;
            end
        end

        settle();
        repeat (16) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
design/rid_pkg.sv
design/rid_ctrl.sv
design/rid_datapath.sv
design/run_index_pixel_decoder_core.sv
test/span_stream_checker.sv
test/tb_run_index_pixel_decoder_core.sv
